// File: src/lrsl_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lrsl_pkg
// Shared types and constants for the longest repeating subsequence core.
// ============================================================================
package lrsl_pkg;

    // Widest string length the job descriptor can carry
    localparam int JOB_LEN_W = 11;

    // Result saturation limit
    localparam logic [5:0] RESULT_MAX = 6'd63;

    // One input byte of the string
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    // One result
    typedef struct packed {
        logic [5:0] repeat_length;
        logic       too_long;
    } result_t;

    // Job handed from the front end to the compute engine
    typedef struct packed {
        logic [JOB_LEN_W-1:0] len;
        logic                 too_long;
    } job_t;

    // Compute engine states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FIN,
        BK_DONE
    } back_state_t;

endpackage

// File: src/lrsl_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lrsl_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module lrsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/lrsl_front.sv
`timescale 1ns / 1ps
// ============================================================================
// lrsl_front
// Input side: stores string bytes, tracks overflow, issues one job per string.
// ============================================================================
module lrsl_front #(
    parameter int MAX_LEN = 64,
    localparam int CW = $clog2(MAX_LEN + 1),
    localparam int AW = $clog2(MAX_LEN)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lrsl_pkg::char_item_t char_item,
    input  logic                back_busy,
    output logic                char_we,
    output logic [AW-1:0]       char_waddr,
    output logic [7:0]          char_wdata,
    output logic                job_valid,
    output lrsl_pkg::job_t      job,
    input  logic                job_take
);

    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic           job_valid_reg, job_valid_next;
    lrsl_pkg::job_t job_reg, job_next;
    logic           accept;
    logic           room;
    logic [CW-1:0]  count_inc;

    // The character store is shared with the engine: hold off while a job is out
    assign full   = job_valid_reg | back_busy;
    assign accept = push & ~full;
    assign room   = (count_reg < CW'(MAX_LEN));

    // Store write port
    assign char_we    = accept & room;
    assign char_waddr = count_reg[AW-1:0];
    assign char_wdata = char_item.char_code;

    assign count_inc = room ? (count_reg + CW'(1)) : count_reg;

    // Load count, overflow flag and job hand-off
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        if (accept)
        begin
            if (char_item.last_char)
            begin
                count_next        = '0;
                ovf_next          = 1'b0;
                job_valid_next    = 1'b1;
                job_next.len      = lrsl_pkg::JOB_LEN_W'(count_inc);
                job_next.too_long = ovf_reg | ~room;
            end
            else
            begin
                count_next = count_inc;
                ovf_next   = ovf_reg | ~room;
            end
        end
        else if (job_take)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

// File: src/lrsl_back.sv
`timescale 1ns / 1ps
// ============================================================================
// lrsl_back
// Compute engine: fills the table one cell per cycle and holds the result.
// ============================================================================
module lrsl_back #(
    parameter int MAX_LEN = 64,
    localparam int CW = $clog2(MAX_LEN + 1),
    localparam int AW = $clog2(MAX_LEN),
    localparam int DW = $clog2(MAX_LEN + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  lrsl_pkg::job_t      job,
    output logic                job_take,
    output logic                busy,
    output logic                char_re,
    output logic [AW-1:0]       row_raddr,
    input  logic [7:0]          row_rdata,
    output logic [AW-1:0]       col_raddr,
    input  logic [7:0]          col_rdata,
    output logic                dp_re,
    output logic [AW-1:0]       dp_raddr,
    input  logic [DW-1:0]       dp_rdata,
    output logic                dp_we,
    output logic [AW-1:0]       dp_waddr,
    output logic [DW-1:0]       dp_wdata,
    input  logic                pop,
    output logic                empty,
    output lrsl_pkg::result_t   result_item
);

    lrsl_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0]     n_reg, n_next;
    logic              tl_reg, tl_next;
    logic [CW-1:0]     i0_reg, i0_next, j0_reg, j0_next;
    logic [CW-1:0]     i1_reg, j1_reg;
    logic              s1_valid_reg;
    logic [DW-1:0]     left_reg, diag_reg;
    logic [DW-1:0]     res_len_reg;
    logic              out_valid_reg, out_valid_next;
    lrsl_pkg::result_t out_item_reg;

    logic          issue, load_out, out_free, last_issue, last_cell;
    logic [DW-1:0] above, left_v, diag_v, best, cell_val;
    logic          match;

    assign out_free   = ~out_valid_reg | pop;
    assign last_issue = (i0_reg == n_reg) && (j0_reg == n_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrsl_pkg::BK_IDLE: if (job_valid) state_next = lrsl_pkg::BK_RUN;
            lrsl_pkg::BK_RUN:  if (last_issue) state_next = lrsl_pkg::BK_FIN;
            lrsl_pkg::BK_FIN:  state_next = lrsl_pkg::BK_DONE;
            lrsl_pkg::BK_DONE: if (out_free) state_next = lrsl_pkg::BK_IDLE;
            default:           state_next = lrsl_pkg::BK_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        job_take = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        busy     = 1'b1;
        case (state_reg)
            lrsl_pkg::BK_IDLE:
            begin
                busy     = 1'b0;
                job_take = job_valid;
            end
            lrsl_pkg::BK_RUN:  issue = 1'b1;
            lrsl_pkg::BK_FIN:  ;
            lrsl_pkg::BK_DONE: load_out = out_free;
            default:           busy = 1'b0;
        endcase
    end

    // Stage 0: cell counters, row-major over the n by n table
    always_comb
    begin
        n_next  = n_reg;
        tl_next = tl_reg;
        i0_next = i0_reg;
        j0_next = j0_reg;
        if (job_take)
        begin
            n_next  = CW'(job.len);
            tl_next = job.too_long;
            i0_next = CW'(1);
            j0_next = CW'(1);
        end
        else if (issue)
        begin
            if (j0_reg == n_reg)
            begin
                j0_next = CW'(1);
                i0_next = i0_reg + CW'(1);
            end
            else
            begin
                j0_next = j0_reg + CW'(1);
            end
        end
    end

    // Memory reads for the cell being issued
    assign char_re   = issue;
    assign dp_re     = issue;
    assign row_raddr = AW'(i0_reg - CW'(1));
    assign col_raddr = AW'(j0_reg - CW'(1));
    assign dp_raddr  = AW'(j0_reg - CW'(1));

    // Stage 1: cell update; row 0 and column 0 read as zero
    assign above    = (i1_reg == CW'(1)) ? '0 : dp_rdata;
    assign left_v   = (j1_reg == CW'(1)) ? '0 : left_reg;
    assign diag_v   = (j1_reg == CW'(1)) ? '0 : diag_reg;
    assign match    = (i1_reg != j1_reg) && (row_rdata == col_rdata);
    assign best     = (above > left_v) ? above : left_v;
    assign cell_val = match ? (diag_v + DW'(1)) : best;

    assign last_cell = s1_valid_reg && (i1_reg == n_reg) && (j1_reg == n_reg);

    assign dp_we    = s1_valid_reg;
    assign dp_waddr = AW'(j1_reg - CW'(1));
    assign dp_wdata = cell_val;

    // Result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrsl_pkg::BK_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg  <= n_next;
        tl_reg <= tl_next;
        i0_reg <= i0_next;
        j0_reg <= j0_next;
        i1_reg <= i0_reg;
        j1_reg <= j0_reg;
        if (s1_valid_reg)
        begin
            left_reg <= cell_val;
            diag_reg <= above;
        end
        if (last_cell)
        begin
            res_len_reg <= cell_val;
        end
        if (load_out)
        begin
            if (32'(res_len_reg) > 32'(lrsl_pkg::RESULT_MAX))
            begin
                out_item_reg.repeat_length <= lrsl_pkg::RESULT_MAX;
            end
            else
            begin
                out_item_reg.repeat_length <= 6'(res_len_reg);
            end
            out_item_reg.too_long <= tl_reg;
        end
    end

    assign empty       = ~out_valid_reg;
    assign result_item = out_item_reg;

endmodule

// File: src/longest_repeating_subsequence_length_core.sv
`timescale 1ns / 1ps
// ============================================================================
// longest_repeating_subsequence_length_core
// Longest repeating subsequence length of a byte string, one result per string.
// ============================================================================
// Bytes are taken one per cycle while a string loads; up to MAX_LEN are kept,
// later ones are dropped and flagged through too_long. After the byte marked
// last, the engine fills the n by n table at one cell per clock (each cell
// needs one read of the row buffer RAM and one of each character store
// copy). The input reports full from the last byte until the result has
// moved into the output register, since the character store is shared; if
// the previous result has not been taken yet, that wait stretches until it
// is. A result in the output register waits there while the next string
// loads.
// ============================================================================
module longest_repeating_subsequence_length_core #(
    parameter int MAX_LEN = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  lrsl_pkg::char_item_t char_item,
    output logic                 empty,
    input  logic                 pop,
    output lrsl_pkg::result_t    result_item
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = $clog2(MAX_LEN + 1);

    logic           back_busy;
    logic           char_we;
    logic [AW-1:0]  char_waddr;
    logic [7:0]     char_wdata;
    logic           job_valid, job_take;
    lrsl_pkg::job_t job;
    logic           char_re;
    logic [AW-1:0]  row_raddr, col_raddr;
    logic [7:0]     row_rdata, col_rdata;
    logic           dp_re, dp_we;
    logic [AW-1:0]  dp_raddr, dp_waddr;
    logic [DW-1:0]  dp_rdata, dp_wdata;

    // Input side
    lrsl_front #(.MAX_LEN(MAX_LEN)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_item  (char_item),
        .back_busy  (back_busy),
        .char_we    (char_we),
        .char_waddr (char_waddr),
        .char_wdata (char_wdata),
        .job_valid  (job_valid),
        .job        (job),
        .job_take   (job_take)
    );

    // Character store, two copies: row byte and column byte read together
    lrsl_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_row_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (char_wdata),
        .re    (char_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    lrsl_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_col_ram (
        .clk   (clk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (char_wdata),
        .re    (char_re),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    // Table row buffer, columns 1..n
    lrsl_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_dp_ram (
        .clk   (clk),
        .we    (dp_we),
        .waddr (dp_waddr),
        .wdata (dp_wdata),
        .re    (dp_re),
        .raddr (dp_raddr),
        .rdata (dp_rdata)
    );

    // Compute engine
    lrsl_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (job),
        .job_take    (job_take),
        .busy        (back_busy),
        .char_re     (char_re),
        .row_raddr   (row_raddr),
        .row_rdata   (row_rdata),
        .col_raddr   (col_raddr),
        .col_rdata   (col_rdata),
        .dp_re       (dp_re),
        .dp_raddr    (dp_raddr),
        .dp_rdata    (dp_rdata),
        .dp_we       (dp_we),
        .dp_waddr    (dp_waddr),
        .dp_wdata    (dp_wdata),
        .pop         (pop),
        .empty       (empty),
        .result_item (result_item)
    );

`ifndef NO_ASSERTIONS
    // Store must not take bytes while the engine reads it
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        back_busy |-> full)
        else $error("input open while engine busy");

    // A last-byte transfer hands a job off and closes the input
    a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && char_item.last_char) |=> full)
        else $error("input still open after last byte");

    // Row buffer read and write never hit the same column in one cycle
    a_dp_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_we && dp_re) |-> (dp_waddr != dp_raddr))
        else $error("row buffer read/write collision");
`endif

endmodule
